[rtl/erm_pkg.sv]
// Package: widths, CORDIC angle table and rounding helpers for the rotation matrix block.
package erm_pkg;
  localparam int ANGLE_W = 17;
  localparam int ENTRY_FRAC_BITS = 16;
  localparam int ENTRY_W = ENTRY_FRAC_BITS + 2;
  localparam int SINCOS_ITERATIONS = 18;
  // Angle conversion (4), fold (1), iterations, output rounding (1)
  localparam int SINCOS_LAT = SINCOS_ITERATIONS + 6;
  localparam int WORK_BITS = 30;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ENTRY_W-1:0] ONE = 18'sd65536;
  // Reciprocals of 45, rounded up; exact for a 17-bit and a 28-bit dividend
  localparam logic [17:0] RECIP_45_HI = 18'd186414;    // 2^23 / 45
  localparam logic [28:0] RECIP_45_LO = 29'd381774871; // 2^34 / 45

  typedef logic signed [ENTRY_W-1:0] entry_t;

  function automatic logic [31:0] atan_bam(input int i);
    logic [31:0] t [0:31];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
          32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
          32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
          32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return t[i[4:0]];
  endfunction

  // Round a 38-bit product sum to entry scale and clamp to plus or minus one
  function automatic entry_t rnd_sat(input logic signed [37:0] v);
    logic signed [37:0] r;
    r = (v + 38'sd32768) >>> ENTRY_FRAC_BITS;
    if (r > 38'sd65536) return ONE;
    if (r < -38'sd65536) return -ONE;
    return entry_t'(r);
  endfunction
endpackage

[rtl/erm_sincos.sv]
// Pipelined CORDIC: one angle in, sine and cosine out, stalls with the shared enable.
module erm_sincos (
  input  logic clk,
  input  logic en,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle,
  output erm_pkg::entry_t sin_out,
  output erm_pkg::entry_t cos_out
);
  import erm_pkg::*;
  localparam int N = SINCOS_ITERATIONS;

  logic [ANGLE_W-1:0] am0, am1;
  logic neg0, neg1, neg2, neg3;
  logic [34:0] hp;
  logic [11:0] h1, h2, h3;
  logic [16:0] rp;
  logic [5:0] r2;
  logic [56:0] fp;
  logic [21:0] f3;
  logic [31:0] q;
  logic [31:0] bam;
  logic signed [CW-1:0] x [0:N];
  logic signed [CW-1:0] y [0:N];
  logic signed [ZW-1:0] z [0:N];
  logic flip [0:N];
  logic signed [CW-1:0] xf, yf, rx, ry;

  // Binary angle is round(|a|*2^22/45); split |a| as 45*h + r so that
  // the result is h*2^22 plus floor((r*2^22 + 22)/45)

  // Take the magnitude and hold the sign
  always_ff @(posedge clk) begin
    if (en) begin
      am0 <= angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
      neg0 <= angle[ANGLE_W-1];
    end
  end

  // Quotient by 45 through the reciprocal
  assign hp = am0 * RECIP_45_HI;

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= hp[34:23];
      am1 <= am0;
      neg1 <= neg0;
    end
  end

  // Remainder by 45
  assign rp = am1 - h1 * 17'd45;

  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= rp[5:0];
      h2 <= h1;
      neg2 <= neg1;
    end
  end

  // Low part of the binary angle, rounded half away from zero
  assign fp = ({r2, 22'd0} + 28'd22) * RECIP_45_LO;

  always_ff @(posedge clk) begin
    if (en) begin
      f3 <= fp[55:34];
      h3 <= h2;
      neg3 <= neg2;
    end
  end

  // Join the parts and restore the sign, modulo a full turn
  assign q = {h3[9:0], f3};
  assign bam = neg3 ? -q : q;

  // Fold the quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      flip[0] <= bam[31] ^ bam[30];
      z[0] <= ZW'(signed'(bam[31] ^ bam[30] ? bam - 32'h80000000 : bam));
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ZW'(atan_bam(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ZW'(atan_bam(i));
        end
      end
    end
  end

  // Unfold and round to entry scale
  always_comb begin
    xf = flip[N] ? -x[N] : x[N];
    yf = flip[N] ? -y[N] : y[N];
    rx = (xf + CW'(1 <<< (WORK_BITS-ENTRY_FRAC_BITS-1))) >>> (WORK_BITS-ENTRY_FRAC_BITS);
    ry = (yf + CW'(1 <<< (WORK_BITS-ENTRY_FRAC_BITS-1))) >>> (WORK_BITS-ENTRY_FRAC_BITS);
  end

  // Clamp and register the outputs
  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= rx > CW'(65536) ? ONE : (rx < -CW'(65536) ? -ONE : entry_t'(rx));
      sin_out <= ry > CW'(65536) ? ONE : (ry < -CW'(65536) ? -ONE : entry_t'(ry));
    end
  end
endmodule

[rtl/euler_rotation_matrix.sv]
// Top level: Euler angle rotation matrix Rx*(Ry*Rz), fully pipelined.
//  channel | signals                         | direction
//  request | in_valid/in_ready, angle_x..z   | in
//  result  | out_valid/out_ready, rowR_colC  | out
// Takes one request per cycle while the output is empty or taken. Stages, in order:
// binary angle conversion, quadrant fold, the CORDIC iterations, rounding, two products.
// Synchronous reset clears the valid bits only.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module euler_rotation_matrix (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_x,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_y,
  input  logic signed [erm_pkg::ANGLE_W-1:0] angle_z,
  output logic out_valid,
  input  logic out_ready,
  output erm_pkg::entry_t row0_col0, output erm_pkg::entry_t row0_col1,
  output erm_pkg::entry_t row0_col2, output erm_pkg::entry_t row1_col0,
  output erm_pkg::entry_t row1_col1, output erm_pkg::entry_t row1_col2,
  output erm_pkg::entry_t row2_col0, output erm_pkg::entry_t row2_col1,
  output erm_pkg::entry_t row2_col2
);
  import erm_pkg::*;
  localparam int LAT = SINCOS_LAT;

  logic en;
  logic [LAT-1:0] vpipe;
  logic v1, v2;
  entry_t sx, cx, sy, cy, sz, cz;
  entry_t p00, p01, p20, p21, nsy, nsz, czr, cyr, sxr, cxr;

  // Advance when the last stage is empty or its result is taken
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  erm_sincos u_x (.clk, .en, .angle(angle_x), .sin_out(sx), .cos_out(cx));
  erm_sincos u_y (.clk, .en, .angle(angle_y), .sin_out(sy), .cos_out(cy));
  erm_sincos u_z (.clk, .en, .angle(angle_z), .sin_out(sz), .cos_out(cz));

  // Carry valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0; v1 <= 1'b0; v2 <= 1'b0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
      v1 <= vpipe[LAT-1];
      v2 <= v1;
    end
  end
  assign out_valid = v2;

  // Form Ry*Rz
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= rnd_sat(38'(cy * cz));
      p01 <= rnd_sat(38'(cy * sz));
      p20 <= rnd_sat(38'(sy * cz));
      p21 <= rnd_sat(38'(sy * sz));
      nsy <= sy == -ONE ? ONE : -sy;
      nsz <= -sz; czr <= cz; cyr <= cy; sxr <= sx; cxr <= cx;
    end
  end

  // Form Rx*P and register the result
  always_ff @(posedge clk) begin
    if (en) begin
      row0_col0 <= p00; row0_col1 <= p01; row0_col2 <= nsy;
      row1_col0 <= rnd_sat(38'(cxr * nsz) + 38'(sxr * p20));
      row1_col1 <= rnd_sat(38'(cxr * czr) + 38'(sxr * p21));
      row1_col2 <= rnd_sat(38'(sxr * cyr));
      row2_col0 <= rnd_sat(38'(-sxr * nsz) + 38'(cxr * p20));
      row2_col1 <= rnd_sat(38'(-sxr * czr) + 38'(cxr * p21));
      row2_col2 <= rnd_sat(38'(cxr * cyr));
    end
  end
endmodule
